>>> hdl/sls_pkg.sv
package sls_pkg;

  // Store geometry
  localparam int NODE_COUNT = 1024;
  localparam int IDX_W      = $clog2(NODE_COUNT);
  localparam int VAL_W      = 32;
  localparam int ACT_W      = 2;
  localparam int ST_W       = 3;
  localparam int UPC_W      = 5;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [VAL_W-1:0] val_t;
  typedef logic [UPC_W-1:0] upc_t;

  // Node 0 heads the free chain, node 1 is always the list head.
  localparam idx_t HEAD_NODE  = IDX_W'(1);
  localparam idx_t FIRST_FREE = IDX_W'(2);
  localparam idx_t LAST_NODE  = IDX_W'(NODE_COUNT - 1);

  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_TOGGLE = 2'd2,
    ACT_LOCATE = 2'd3
  } action_t;

  typedef enum logic [ST_W-1:0] {
    ST_CLEARED   = 3'd0,
    ST_APPENDED  = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_REMOVED   = 3'd3,
    ST_FOUND     = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_FULL      = 3'd6
  } status_t;

  // Read address source
  typedef enum logic [2:0] {
    RS_NONE, RS_FREE, RS_TAIL, RS_HEAD, RS_LINK
  } rsel_t;

  // Link write: address / data pair
  typedef enum logic [2:0] {
    WS_NONE,
    WS_SWEEP,       // links[cnt]  = rebuild pattern
    WS_P_TMP,       // links[p]    = tmp
    WS_K_FREE,      // links[k]    = free
    WS_FREE_STOP,   // links[free] = stop
    WS_FREE_LINK,   // links[free] = read link
    WS_TAIL_FREE    // links[tail] = free
  } wsel_t;

  // Register operation
  typedef enum logic [3:0] {
    OP_NONE,
    OP_P_HEAD,
    OP_LD_STOP,
    OP_LD_K,
    OP_WALK,
    OP_LD_TMP,
    OP_CLR_DONE,
    OP_APPEND_DONE,
    OP_INSERT_DONE,
    OP_REMOVE_DONE
  } op_t;

  // Sequencing
  typedef enum logic [2:0] {
    JMP_NEXT,
    JMP_END,
    JMP_FREE0,   // free chain empty -> target
    JMP_SWEEP,   // hold until last node written
    JMP_TWALK,   // end of range -> target, hit -> next, else hold
    JMP_LWALK    // end of list  -> target, hit -> next, else hold
  } jmp_t;

  // Source of the reported node index
  typedef enum logic [1:0] {
    NS_ZERO, NS_ONE, NS_FREE, NS_K
  } nsel_t;

  typedef struct packed {
    rsel_t   rsel;
    wsel_t   wsel;
    logic    vw;
    op_t     op;
    jmp_t    jmp;
    upc_t    target;
    logic    emit;
    status_t status;
    nsel_t   nsel;
  } ctl_t;

  typedef struct packed {
    logic free_zero;
    logic k_zero;
    logic k_stop;
    logic match;
    logic sweep_last;
  } flags_t;

  // Microprogram step addresses
  localparam upc_t U_SWEEP = UPC_W'(0);
  localparam upc_t U_CLR   = UPC_W'(1);
  localparam upc_t U_A0    = UPC_W'(2);
  localparam upc_t U_A1    = UPC_W'(3);
  localparam upc_t U_A2    = UPC_W'(4);
  localparam upc_t U_A3    = UPC_W'(5);
  localparam upc_t U_T0    = UPC_W'(6);
  localparam upc_t U_T1    = UPC_W'(7);
  localparam upc_t U_T2    = UPC_W'(8);
  localparam upc_t U_T3    = UPC_W'(9);
  localparam upc_t U_T4    = UPC_W'(10);
  localparam upc_t U_T5    = UPC_W'(11);
  localparam upc_t U_I0    = UPC_W'(12);
  localparam upc_t U_I1    = UPC_W'(13);
  localparam upc_t U_I2    = UPC_W'(14);
  localparam upc_t U_L0    = UPC_W'(15);
  localparam upc_t U_L1    = UPC_W'(16);
  localparam upc_t U_L2    = UPC_W'(17);
  localparam upc_t U_L3    = UPC_W'(18);
  localparam upc_t U_FULL  = UPC_W'(19);
  localparam upc_t U_LNF   = UPC_W'(20);

  localparam ctl_t CTL_IDLE = '{
    rsel: RS_NONE, wsel: WS_NONE, vw: 1'b0, op: OP_NONE, jmp: JMP_NEXT,
    target: U_SWEEP, emit: 1'b0, status: ST_CLEARED, nsel: NS_ZERO
  };

  function automatic ctl_t uw(input rsel_t r, input wsel_t w, input logic v,
                              input op_t o, input jmp_t j, input upc_t t,
                              input logic e, input status_t s, input nsel_t n);
    ctl_t c;
    c = '{rsel: r, wsel: w, vw: v, op: o, jmp: j, target: t,
          emit: e, status: s, nsel: n};
    return c;
  endfunction

  // Control store
  function automatic ctl_t ucode(input upc_t pc);
    ctl_t c;
    c = CTL_IDLE;
    case (pc)
      U_SWEEP: c = uw(RS_NONE, WS_SWEEP, 1'b0, OP_NONE, JMP_SWEEP, U_SWEEP,
                      1'b0, ST_CLEARED, NS_ZERO);
      U_CLR:   c = uw(RS_NONE, WS_NONE, 1'b0, OP_CLR_DONE, JMP_END, U_SWEEP,
                      1'b1, ST_CLEARED, NS_ONE);
      // append
      U_A0:    c = uw(RS_FREE, WS_NONE, 1'b0, OP_NONE, JMP_FREE0, U_FULL,
                      1'b0, ST_CLEARED, NS_ZERO);
      U_A1:    c = uw(RS_TAIL, WS_NONE, 1'b0, OP_LD_TMP, JMP_NEXT, U_SWEEP,
                      1'b0, ST_CLEARED, NS_ZERO);
      U_A2:    c = uw(RS_NONE, WS_FREE_LINK, 1'b1, OP_NONE, JMP_NEXT, U_SWEEP,
                      1'b0, ST_CLEARED, NS_ZERO);
      U_A3:    c = uw(RS_NONE, WS_TAIL_FREE, 1'b0, OP_APPEND_DONE, JMP_END, U_SWEEP,
                      1'b1, ST_APPENDED, NS_FREE);
      // toggle: search
      U_T0:    c = uw(RS_TAIL, WS_NONE, 1'b0, OP_P_HEAD, JMP_NEXT, U_SWEEP,
                      1'b0, ST_CLEARED, NS_ZERO);
      U_T1:    c = uw(RS_HEAD, WS_NONE, 1'b0, OP_LD_STOP, JMP_NEXT, U_SWEEP,
                      1'b0, ST_CLEARED, NS_ZERO);
      U_T2:    c = uw(RS_LINK, WS_NONE, 1'b0, OP_LD_K, JMP_NEXT, U_SWEEP,
                      1'b0, ST_CLEARED, NS_ZERO);
      U_T3:    c = uw(RS_LINK, WS_NONE, 1'b0, OP_WALK, JMP_TWALK, U_I0,
                      1'b0, ST_CLEARED, NS_ZERO);
      // toggle: remove
      U_T4:    c = uw(RS_NONE, WS_P_TMP, 1'b0, OP_NONE, JMP_NEXT, U_SWEEP,
                      1'b0, ST_CLEARED, NS_ZERO);
      U_T5:    c = uw(RS_NONE, WS_K_FREE, 1'b0, OP_REMOVE_DONE, JMP_END, U_SWEEP,
                      1'b1, ST_REMOVED, NS_K);
      // toggle: insert after tail
      U_I0:    c = uw(RS_FREE, WS_NONE, 1'b0, OP_NONE, JMP_FREE0, U_FULL,
                      1'b0, ST_CLEARED, NS_ZERO);
      U_I1:    c = uw(RS_NONE, WS_FREE_STOP, 1'b1, OP_LD_TMP, JMP_NEXT, U_SWEEP,
                      1'b0, ST_CLEARED, NS_ZERO);
      U_I2:    c = uw(RS_NONE, WS_TAIL_FREE, 1'b0, OP_INSERT_DONE, JMP_END, U_SWEEP,
                      1'b1, ST_INSERTED, NS_FREE);
      // locate
      U_L0:    c = uw(RS_HEAD, WS_NONE, 1'b0, OP_NONE, JMP_NEXT, U_SWEEP,
                      1'b0, ST_CLEARED, NS_ZERO);
      U_L1:    c = uw(RS_LINK, WS_NONE, 1'b0, OP_LD_K, JMP_NEXT, U_SWEEP,
                      1'b0, ST_CLEARED, NS_ZERO);
      U_L2:    c = uw(RS_LINK, WS_NONE, 1'b0, OP_WALK, JMP_LWALK, U_LNF,
                      1'b0, ST_CLEARED, NS_ZERO);
      U_L3:    c = uw(RS_NONE, WS_NONE, 1'b0, OP_NONE, JMP_END, U_SWEEP,
                      1'b1, ST_FOUND, NS_K);
      U_FULL:  c = uw(RS_NONE, WS_NONE, 1'b0, OP_NONE, JMP_END, U_SWEEP,
                      1'b1, ST_FULL, NS_ZERO);
      U_LNF:   c = uw(RS_NONE, WS_NONE, 1'b0, OP_NONE, JMP_END, U_SWEEP,
                      1'b1, ST_NOT_FOUND, NS_ZERO);
      default: c = CTL_IDLE;
    endcase
    return c;
  endfunction

  function automatic upc_t entry(input action_t a);
    upc_t pc;
    pc = U_SWEEP;
    case (a)
      ACT_CLEAR:  pc = U_SWEEP;
      ACT_APPEND: pc = U_A0;
      ACT_TOGGLE: pc = U_T0;
      ACT_LOCATE: pc = U_L0;
      default:    pc = U_SWEEP;
    endcase
    return pc;
  endfunction

endpackage

>>> hdl/sls_ram.sv
module sls_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/sls_seq.sv
module sls_seq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  sls_pkg::action_t action,
  input  sls_pkg::flags_t  flg,
  output sls_pkg::ctl_t    ctl,
  output logic             busy,
  output logic             adv
);

  import sls_pkg::*;

  upc_t upc_r, upc_nxt, upc_inc;
  logic busy_r, busy_nxt;
  logic quiet_r, quiet_nxt;   // reset sweep: no result
  ctl_t word;

  assign upc_inc = upc_r + 1'b1;

  always_comb begin
    word      = ucode(upc_r);
    upc_nxt   = upc_r;
    busy_nxt  = busy_r;
    quiet_nxt = quiet_r;
    adv       = 1'b0;
    if (!busy_r) begin
      if (start) begin
        upc_nxt  = entry(action);
        busy_nxt = 1'b1;
      end
    end else begin
      case (word.jmp)
        JMP_NEXT:  upc_nxt = upc_inc;
        JMP_END: begin
          busy_nxt  = 1'b0;
          quiet_nxt = 1'b0;
        end
        JMP_FREE0: upc_nxt = flg.free_zero ? word.target : upc_inc;
        JMP_SWEEP: begin
          if (flg.sweep_last) upc_nxt = upc_inc;
        end
        JMP_TWALK: begin
          if (flg.k_zero || flg.k_stop) upc_nxt = word.target;
          else if (flg.match)           upc_nxt = upc_inc;
          else                          adv     = 1'b1;
        end
        JMP_LWALK: begin
          if (flg.k_zero)     upc_nxt = word.target;
          else if (flg.match) upc_nxt = upc_inc;
          else                adv     = 1'b1;
        end
        default: upc_nxt = upc_inc;
      endcase
    end
    ctl      = busy_r ? word : CTL_IDLE;
    ctl.emit = word.emit & busy_r & ~quiet_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r   <= U_SWEEP;
      busy_r  <= 1'b1;
      quiet_r <= 1'b1;
    end else begin
      upc_r   <= upc_nxt;
      busy_r  <= busy_nxt;
      quiet_r <= quiet_nxt;
    end
  end

  assign busy = busy_r;

endmodule

>>> hdl/static_list_set_toggle.sv
// Per transfer: clear sweeps the link rebuild, then reports; append takes a free node
// (or reports full) and links it after the tail; toggle walks one node a cycle to a
// hit or the range end, then removes the hit or inserts after the tail; locate walks
// to a hit or the list end. One item at a time; busy drops in the cycle the result is
// shown. Reset (synchronous, active low) runs the same link rebuild as clear,
// with busy high and no result. Results are one-cycle strobes: no back pressure.
module static_list_set_toggle (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [sls_pkg::ACT_W-1:0]     in_action,
  input  logic signed [sls_pkg::VAL_W-1:0] in_value,
  output logic                          out_valid,
  output logic [sls_pkg::ST_W-1:0]      out_status,
  output logic [sls_pkg::IDX_W-1:0]     out_node_index
);

  import sls_pkg::*;

  // ---------------------------------------------------------------
  // Sequencer: step counter + control store, one word per cycle
  // ---------------------------------------------------------------
  ctl_t   ctl;
  flags_t flg;
  logic   adv;      // walk step missed: move on to the next node
  logic   seq_busy;
  logic   accept;

  sls_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (action_t'(in_action)),
    .flg    (flg),
    .ctl    (ctl),
    .busy   (seq_busy),
    .adv    (adv)
  );

  assign busy   = seq_busy;
  assign accept = start & ~seq_busy;

  // ---------------------------------------------------------------
  // Datapath registers
  //   free_r : head of the free chain (stands in for links[0])
  //   tail_r : list tail; the head is always node 1
  //   k_r    : node under test in a walk, p_r its predecessor
  //   stop_r : link out of the tail at the start of a toggle
  //   tmp_r  : scratch link (next free node, or successor of k)
  //   cnt_r  : rebuild sweep address
  // ---------------------------------------------------------------
  idx_t free_r, free_nxt;
  idx_t tail_r, tail_nxt;
  idx_t k_r, k_nxt;
  idx_t p_r, p_nxt;
  idx_t stop_r, stop_nxt;
  idx_t tmp_r, tmp_nxt;
  idx_t cnt_r, cnt_nxt;
  val_t value_r, value_nxt;

  // Node store: links and values share one read address, so a walk
  // step gets both the successor and the payload of k together.
  idx_t rd_addr;
  idx_t lk_rd;
  val_t vl_rd;
  logic lk_we;
  idx_t lk_waddr, lk_wdata;

  sls_ram #(.WIDTH(IDX_W), .DEPTH(NODE_COUNT)) u_links (
    .clk   (clk),
    .we    (lk_we),
    .waddr (lk_waddr),
    .wdata (lk_wdata),
    .raddr (rd_addr),
    .rdata (lk_rd)
  );

  // Values are written only for allocated nodes; a walk never reads
  // past a written node, so no clearing is needed here.
  sls_ram #(.WIDTH(VAL_W), .DEPTH(NODE_COUNT)) u_values (
    .clk   (clk),
    .we    (ctl.vw),
    .waddr (free_r),
    .wdata (value_r),
    .raddr (rd_addr),
    .rdata (vl_rd)
  );

  // Read address. RS_LINK chases the link just read, so the walk
  // issues the next node's read in the same cycle it tests the current one.
  always_comb begin
    case (ctl.rsel)
      RS_FREE: rd_addr = free_r;
      RS_TAIL: rd_addr = tail_r;
      RS_HEAD: rd_addr = HEAD_NODE;
      RS_LINK: rd_addr = lk_rd;
      default: rd_addr = '0;
    endcase
  end

  // Link write port
  always_comb begin
    lk_we    = 1'b1;
    lk_waddr = '0;
    lk_wdata = '0;
    case (ctl.wsel)
      WS_SWEEP: begin
        // rebuild: links[i] = i+1, chain ends at the last node, and
        // node 1 is already taken as the head (links[1] = 0)
        lk_waddr = cnt_r;
        lk_wdata = (cnt_r == HEAD_NODE || cnt_r == LAST_NODE) ? '0 : cnt_r + 1'b1;
      end
      WS_P_TMP: begin
        lk_waddr = p_r;
        lk_wdata = tmp_r;
      end
      WS_K_FREE: begin
        lk_waddr = k_r;
        lk_wdata = free_r;
      end
      WS_FREE_STOP: begin
        lk_waddr = free_r;
        lk_wdata = stop_r;
      end
      WS_FREE_LINK: begin
        lk_waddr = free_r;
        lk_wdata = lk_rd;
      end
      WS_TAIL_FREE: begin
        lk_waddr = tail_r;
        lk_wdata = free_r;
      end
      default: lk_we = 1'b0;
    endcase
  end

  // Branch conditions back to the sequencer
  assign flg.free_zero  = (free_r == '0);
  assign flg.k_zero     = (k_r == '0);
  assign flg.k_stop     = (k_r == stop_r);
  assign flg.match      = (vl_rd == value_r);
  assign flg.sweep_last = (cnt_r == LAST_NODE);

  always_comb begin
    free_nxt  = free_r;
    tail_nxt  = tail_r;
    k_nxt     = k_r;
    p_nxt     = p_r;
    stop_nxt  = stop_r;
    tmp_nxt   = tmp_r;
    cnt_nxt   = cnt_r;
    value_nxt = value_r;

    if (accept) begin
      value_nxt = in_value;
      cnt_nxt   = HEAD_NODE;   // sweep starts past the free-chain anchor
    end
    if (ctl.wsel == WS_SWEEP) begin
      cnt_nxt = cnt_r + 1'b1;
    end

    case (ctl.op)
      OP_P_HEAD:  p_nxt    = HEAD_NODE;
      OP_LD_STOP: stop_nxt = lk_rd;
      OP_LD_K:    k_nxt    = lk_rd;
      OP_WALK: begin
        // successor of k kept for an unlink on a hit
        tmp_nxt = lk_rd;
        if (adv) begin
          p_nxt = k_r;
          k_nxt = lk_rd;
        end
      end
      OP_LD_TMP:  tmp_nxt = lk_rd;
      OP_CLR_DONE: begin
        free_nxt = FIRST_FREE;
        tail_nxt = HEAD_NODE;
      end
      OP_APPEND_DONE: begin
        free_nxt = tmp_r;
        tail_nxt = free_r;
      end
      OP_INSERT_DONE: free_nxt = tmp_r;   // tail stays put
      OP_REMOVE_DONE: begin
        free_nxt = k_r;
        if (tail_r == k_r) tail_nxt = p_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= HEAD_NODE;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    free_r  <= free_nxt;
    tail_r  <= tail_nxt;
    k_r     <= k_nxt;
    p_r     <= p_nxt;
    stop_r  <= stop_nxt;
    tmp_r   <= tmp_nxt;
    value_r <= value_nxt;
  end

  // ---------------------------------------------------------------
  // Result register: one-cycle strobe per transfer
  // ---------------------------------------------------------------
  logic    out_valid_r;
  status_t out_status_r;
  idx_t    out_node_r, node_sel;

  always_comb begin
    case (ctl.nsel)
      NS_ONE:  node_sel = HEAD_NODE;
      NS_FREE: node_sel = free_r;
      NS_K:    node_sel = k_r;
      default: node_sel = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= ctl.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit) begin
      out_status_r <= ctl.status;
      out_node_r   <= node_sel;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_node_index = out_node_r;

endmodule

>>> hdl/sls_chk.sv
module sls_chk (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      start,
  input logic                      busy,
  input logic                      out_valid,
  input logic [sls_pkg::ST_W-1:0]  out_status,
  input logic [sls_pkg::IDX_W-1:0] out_node_index
);

  import sls_pkg::*;

  // result shows only once the item is done
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("transfer did not raise busy");

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("two results back to back");

  a_clear_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_CLEARED |-> out_node_index == HEAD_NODE)
    else $error("clear did not report the head node");

  a_none_node: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_NOT_FOUND)
      |-> out_node_index == '0)
    else $error("nonzero node on full or not found");

endmodule

bind static_list_set_toggle sls_chk u_sls_chk (.*);
